@@ sv/u8u16_pkg.sv @@
`default_nettype none

package u8u16_pkg;

	localparam int MAX_UNITS = 4;
	localparam int QUEUE_DEPTH = 2;

	// high byte of an escaped raw byte, 0xdc00 + byte
	localparam logic [7:0] ESC_HI = 8'hDC;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	typedef logic [15:0] unit_t;

	// one accepted byte worth of output units
	typedef struct packed {
		logic [2:0] n;
		logic last;
		unit_t [MAX_UNITS-1:0] unit;
	} job_t;

	function automatic unit_t esc_unit(input logic [7:0] b);
		return {ESC_HI, b};
	endfunction

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_NONE;
		if (b[7:5] == 3'b110) begin
			len = LEN_TWO;
		end else if (b[7:4] == 4'b1110) begin
			len = LEN_THREE;
		end else if (b[7:3] == 5'b11110) begin
			len = LEN_FOUR;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

@@ sv/u8u16_front.sv @@
`default_nettype none

module u8u16_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        byte_in,
	input  wire logic              last_byte,
	input  wire logic              q_full,
	output logic                   push,
	output u8u16_pkg::job_t        job
);
	import u8u16_pkg::*;

	logic [7:0] pend_q [3];
	logic [7:0] pend_n [3];
	logic [1:0] cnt_q, cnt_n;
	logic [2:0] elen_q, elen_n;
	logic       accept;
	logic       seq_idle;
	logic       is_cont;
	logic       do_start;
	logic       bad_cp;
	logic [20:0] cp;
	logic [20:0] cp_min;
	logic [20:0] adj;
	logic [2:0] start_len;
	logic [2:0] n;
	unit_t [MAX_UNITS-1:0] units;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// code point assembly for a sequence that completes with this byte
	always_comb begin
		unique case (elen_q)
			LEN_TWO: begin
				cp = {10'd0, pend_q[0][4:0], byte_in[5:0]};
				cp_min = 21'h00080;
			end
			LEN_THREE: begin
				cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], byte_in[5:0]};
				cp_min = 21'h00800;
			end
			default: begin
				cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], byte_in[5:0]};
				cp_min = 21'h10000;
			end
		endcase
		bad_cp = (cp < cp_min) || (cp > 21'h10FFFF) ||
			((cp >= 21'h00D800) && (cp <= 21'h00DFFF));
		adj = cp - 21'h10000;
	end

	always_comb begin
		n = 3'd0;
		units = '0;
		pend_n = pend_q;
		cnt_n = cnt_q;
		elen_n = elen_q;
		do_start = 1'b0;
		start_len = lead_len(byte_in);
		seq_idle = (cnt_q == 2'd0) || (elen_q < LEN_TWO) || (elen_q > LEN_FOUR) ||
			({1'b0, cnt_q} >= elen_q);
		is_cont = (byte_in[7:6] == 2'b10);

		if (seq_idle) begin
			cnt_n = 2'd0;
			elen_n = LEN_NONE;
			do_start = 1'b1;
		end else if (!is_cont) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < cnt_q) begin
					units[n[1:0]] = esc_unit(pend_q[i]);
					n = n + 3'd1;
				end
			end
			cnt_n = 2'd0;
			elen_n = LEN_NONE;
			do_start = 1'b1;
		end else if (({1'b0, cnt_q} + 3'd1) == elen_q) begin
			cnt_n = 2'd0;
			elen_n = LEN_NONE;
			if (bad_cp) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < cnt_q) begin
						units[n[1:0]] = esc_unit(pend_q[i]);
						n = n + 3'd1;
					end
				end
				units[n[1:0]] = esc_unit(byte_in);
				n = n + 3'd1;
			end else if (cp[20:16] == 5'd0) begin
				units[n[1:0]] = cp[15:0];
				n = n + 3'd1;
			end else begin
				// surrogate pair
				units[n[1:0]] = {6'b110110, adj[19:10]};
				n = n + 3'd1;
				units[n[1:0]] = {6'b110111, adj[9:0]};
				n = n + 3'd1;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (cnt_q == 2'(i)) begin
					pend_n[i] = byte_in;
				end
			end
			cnt_n = cnt_q + 2'd1;
		end

		if (do_start) begin
			if (!byte_in[7]) begin
				units[n[1:0]] = {8'h00, byte_in};
				n = n + 3'd1;
			end else if (start_len != LEN_NONE) begin
				pend_n[0] = byte_in;
				cnt_n = 2'd1;
				elen_n = start_len;
			end else begin
				units[n[1:0]] = esc_unit(byte_in);
				n = n + 3'd1;
			end
		end

		// end of name: escape whatever is still held
		if (last_byte && (cnt_n != 2'd0)) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < cnt_n) begin
					units[n[1:0]] = esc_unit(pend_n[i]);
					n = n + 3'd1;
				end
			end
			cnt_n = 2'd0;
			elen_n = LEN_NONE;
		end
	end

	assign push = accept && (n != 3'd0);
	assign job.n = n;
	assign job.last = last_byte;
	assign job.unit = units;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			elen_q <= LEN_NONE;
		end else if (accept) begin
			cnt_q <= cnt_n;
			elen_q <= elen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= pend_n;
		end
	end

endmodule

`default_nettype wire

@@ sv/u8u16_fifo.sv @@
`default_nettype none

module u8u16_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u8u16_pkg::job_t wr_data,
	output logic                 full,
	input  wire logic            pop,
	output logic                 rd_valid,
	output u8u16_pkg::job_t      rd_data
);
	import u8u16_pkg::*;

	job_t       mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ sv/u8u16_back.sv @@
`default_nettype none

module u8u16_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire u8u16_pkg::job_t q_head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [15:0]          code_unit,
	output logic                 run_last,
	output logic                 name_end
);
	import u8u16_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	unit_t      unit_q;
	logic       run_last_q;
	logic       name_end_q;
	logic       load;
	logic       is_last;

	assign load = q_valid && (!out_valid_q || !out_stall);
	assign is_last = ({1'b0, idx_q} + 3'd1) == q_head.n;
	assign pop = load && is_last;

	assign out_valid = out_valid_q;
	assign code_unit = unit_q;
	assign run_last = run_last_q;
	assign name_end = name_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= q_head.unit[idx_q];
			run_last_q <= is_last;
			name_end_q <= is_last && q_head.last;
		end
	end

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_end |-> run_last)
		else $error("name_end without run_last");

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> ({1'b0, idx_q} < q_head.n) && (q_head.n <= 3'(MAX_UNITS)))
		else $error("unit index beyond job size");

	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		load && !is_last |=> q_valid && (idx_q != 2'd0))
		else $error("job left queue before its last unit");

endmodule

`default_nettype wire

@@ sv/utf8_to_utf16_escape_decoder.sv @@
`default_nettype none

// Strict UTF-8 to UTF-16 decoder that escapes undecodable bytes as 0xdc00 + byte.
// One byte is accepted per cycle as long as the queue between the decoder front
// and the unit sequencer has room; a byte that yields k code units (k = 0..4)
// is queued, if k is nonzero, until the back end, which emits one unit per cycle
// while out_stall is low, has loaded its last unit into the output register. The first
// unit of a byte is written to the queue and then registered in the output register.
// A two-entry queue absorbs multi-unit bursts so the input keeps flowing while the output catches up or is stalled.

module utf8_to_utf16_escape_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             run_last,
	output logic             name_end
);
	import u8u16_pkg::*;

	logic q_full;
	logic push;
	logic pop;
	logic q_valid;
	job_t job;
	job_t q_head;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.byte_in   (byte_in),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.job       (job)
	);

	u8u16_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_data  (q_head)
	);

	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code_unit (code_unit),
		.run_last  (run_last),
		.name_end  (name_end)
	);

endmodule

`default_nettype wire

@@ bench/tb_utf8_to_utf16_escape_decoder.sv @@
module tb_utf8_to_utf16_escape_decoder;

	import u8u16_pkg::*;

	localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE = 16'hDC00;
	localparam int unsigned SURR_FIRST = 32'hD800;
	localparam int unsigned SURR_LAST = 32'hDFFF;
	localparam int unsigned PLANE1_START = 32'h10000;
	localparam int unsigned CODE_POINT_MAX = 32'h10FFFF;
	localparam int unsigned MIN_TWO = 32'h80;
	localparam int unsigned MIN_THREE = 32'h800;

	typedef struct packed {
		logic [15:0] cu;
		logic run_last;
		logic name_end;
	} unit_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] byte_in = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] code_unit;
	logic run_last;
	logic name_end;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatch_count = 0;

	// decoder state as the predictor sees it
	logic [7:0] held_bytes [3];
	int unsigned held_count = 0;
	int unsigned seq_len = 0;

	logic [15:0] step_units[$];
	unit_rec_t expected_units[$];
	logic [7:0] name_bytes[$];

	utf8_to_utf16_escape_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_unit(code_unit),
		.run_last(run_last),
		.name_end(name_end)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void flush_held();
		int unsigned i;
		for (i = 0; i < held_count; i++) begin
			step_units.push_back({ESC_HI, held_bytes[i]});
		end
		held_count = 0;
		seq_len = 0;
	endfunction

	function automatic void start_lead(input logic [7:0] b);
		int unsigned len;
		len = 0;
		if (b[7] == 1'b0) begin
			step_units.push_back({8'h00, b});
			return;
		end
		casez (b)
			8'b110?????: len = 2;
			8'b1110????: len = 3;
			8'b11110???: len = 4;
			default: len = 0;
		endcase
		if (len == 0) begin
			step_units.push_back({ESC_HI, b});
		end else begin
			held_bytes[0] = b;
			held_count = 1;
			seq_len = len;
		end
	endfunction

	function automatic void complete_seq(input logic [7:0] b);
		int unsigned cp;
		int unsigned floor_cp;
		int unsigned adj;
		int unsigned i;
		case (seq_len)
			2: begin
				cp = 32'(held_bytes[0][4:0]);
				floor_cp = MIN_TWO;
			end
			3: begin
				cp = 32'(held_bytes[0][3:0]);
				floor_cp = MIN_THREE;
			end
			default: begin
				cp = 32'(held_bytes[0][2:0]);
				floor_cp = PLANE1_START;
			end
		endcase
		for (i = 1; i < held_count; i++) begin
			cp = (cp << 6) | 32'(held_bytes[i][5:0]);
		end
		cp = (cp << 6) | 32'(b[5:0]);
		// overlong, surrogate or out of range: escape the whole sequence
		if (cp < floor_cp || cp > CODE_POINT_MAX || (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
			flush_held();
			step_units.push_back({ESC_HI, b});
			return;
		end
		held_count = 0;
		seq_len = 0;
		if (cp < PLANE1_START) begin
			step_units.push_back(cp[15:0]);
		end else begin
			adj = cp - PLANE1_START;
			step_units.push_back(HIGH_SURR_BASE + 16'(adj[19:10]));
			step_units.push_back(LOW_SURR_BASE + 16'(adj[9:0]));
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic lst);
		int unsigned i;
		unit_rec_t rec;
		step_units.delete();
		if (held_count == 0) begin
			start_lead(b);
		end else if (b[7:6] != 2'b10) begin
			flush_held();
			start_lead(b);
		end else if (held_count + 1 == seq_len) begin
			complete_seq(b);
		end else begin
			held_bytes[held_count] = b;
			held_count++;
		end
		if (lst && held_count > 0) begin
			flush_held();
		end
		for (i = 0; i < step_units.size(); i++) begin
			rec.cu = step_units[i];
			rec.run_last = (i == step_units.size() - 1);
			rec.name_end = lst && (i == step_units.size() - 1);
			expected_units.push_back(rec);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_unit();
		unit_rec_t want;
		if (expected_units.size() == 0) begin
			report_mismatch("code unit with nothing pending", code_unit, 16'h0000);
			return;
		end
		want = expected_units.pop_front();
		if (code_unit !== want.cu) begin
			report_mismatch("code_unit", code_unit, want.cu);
		end
		if (run_last !== want.run_last) begin
			report_mismatch("run_last", 16'(run_last), 16'(want.run_last));
		end
		if (name_end !== want.name_end) begin
			report_mismatch("name_end", 16'(name_end), 16'(want.name_end));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_unit();
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// one transaction; prediction runs at the edge that accepts it
	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		last_byte <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_byte(b, lst);
	endtask

	task automatic send_name_bytes();
		int unsigned i;
		for (i = 0; i < name_bytes.size(); i++) begin
			send_byte(name_bytes[i], i == name_bytes.size() - 1);
		end
	endtask

	function automatic void append_utf8(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: name_bytes.push_back(cp[7:0]);
			2: begin
				name_bytes.push_back({3'b110, cp[10:6]});
				name_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				name_bytes.push_back({4'b1110, cp[15:12]});
				name_bytes.push_back({2'b10, cp[11:6]});
				name_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				name_bytes.push_back({5'b11110, cp[20:18]});
				name_bytes.push_back({2'b10, cp[17:12]});
				name_bytes.push_back({2'b10, cp[11:6]});
				name_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic int unsigned random_code_point(input int unsigned len);
		int unsigned cp;
		case (len)
			1: cp = $urandom_range(0, MIN_TWO - 1);
			2: cp = $urandom_range(MIN_TWO, MIN_THREE - 1);
			3: begin
				cp = $urandom_range(MIN_THREE, PLANE1_START - 1);
				if (cp >= SURR_FIRST && cp <= SURR_LAST) begin
					cp = cp - MIN_THREE;
				end
			end
			default: cp = $urandom_range(PLANE1_START, CODE_POINT_MAX);
		endcase
		return cp;
	endfunction

	task automatic test_ascii_and_stray();
		// ascii extremes, then stray continuation and invalid lead bytes
		name_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF};
		send_name_bytes();
	endtask

	task automatic test_valid_sequences();
		name_bytes = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_name_bytes();
	endtask

	task automatic test_rejected_values();
		// overlong C1 lead, encoded surrogate, F5 lead above the code space
		name_bytes = '{8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF5, 8'h80, 8'h80, 8'h80};
		send_name_bytes();
	endtask

	task automatic test_broken_sequences();
		// bad continuation after two held bytes, new lead then completes
		name_bytes = '{8'hE2, 8'h82, 8'hC3, 8'hA9};
		send_name_bytes();
		// three held bytes interrupted by a lead that the name end flushes
		name_bytes = '{8'hF0, 8'h90, 8'h80, 8'hF0};
		send_name_bytes();
	endtask

	task automatic test_random_names(input int unsigned n_bytes);
		int unsigned sent;
		int unsigned n_chars;
		int unsigned k;
		int unsigned kind;
		int unsigned len;
		int unsigned cp;
		int unsigned cut;
		sent = 0;
		while (sent < n_bytes) begin
			name_bytes.delete();
			n_chars = $urandom_range(1, 5);
			for (k = 0; k < n_chars; k++) begin
				kind = $urandom_range(99);
				len = $urandom_range(1, 4);
				if (kind < 60) begin
					append_utf8(21'(random_code_point(len)), len);
				end else if (kind < 72) begin
					name_bytes.push_back(8'($urandom_range(255)));
				end else if (kind < 88) begin
					// truncated sequence, sometimes followed by any byte
					len = $urandom_range(2, 4);
					append_utf8(21'(random_code_point(len)), len);
					cut = $urandom_range(1, len - 1);
					repeat (cut) void'(name_bytes.pop_back());
					if ($urandom_range(1)) begin
						name_bytes.push_back(8'($urandom_range(255)));
					end
				end else begin
					case ($urandom_range(2))
						0: begin
							len = $urandom_range(2, 4);
							cp = (len == 2) ? $urandom_range(0, MIN_TWO - 1) :
								(len == 3) ? $urandom_range(0, MIN_THREE - 1) :
								$urandom_range(0, PLANE1_START - 1);
						end
						1: begin
							len = 3;
							cp = $urandom_range(SURR_FIRST, SURR_LAST);
						end
						default: begin
							len = 4;
							cp = $urandom_range(CODE_POINT_MAX + 1, 32'h1FFFFF);
						end
					endcase
					append_utf8(21'(cp), len);
				end
			end
			send_name_bytes();
			sent += name_bytes.size();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 32;
		stall_pct = 54;
		test_ascii_and_stray();
		test_valid_sequences();
		test_rejected_values();
		test_broken_sequences();
		test_random_names(40);
		send_idle_pct = 54;
		stall_pct = 32;
		test_random_names(40);
		send_idle_pct = 0;
		stall_pct = 0;
		test_random_names(40);
		in_valid <= 1'b0;
		while (expected_units.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_utf8_to_utf16_escape_decoder: PASS");
		end else begin
			$display("tb_utf8_to_utf16_escape_decoder: FAIL");
		end
		$finish;
	end

	initial begin
		#1200000;
		$display("tb_utf8_to_utf16_escape_decoder: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
sv/u8u16_pkg.sv
sv/u8u16_front.sv
sv/u8u16_fifo.sv
sv/u8u16_back.sv
sv/utf8_to_utf16_escape_decoder.sv
bench/tb_utf8_to_utf16_escape_decoder.sv
